FILE: rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants for the retransmit timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int SHIFT_CAP_DEF   = 6;
    localparam int MAX_RES         = 32;
    localparam int MIN_BACKOFF     = 100;
    localparam int ARM_MAX         = 131071;
    localparam int RECIP_SHIFT     = 30;
    localparam int RECIP_M         = 10737418;   // floor(2^30 / 100)
    localparam int PADDR_W         = 5;

    localparam logic [2:0] MODE_SEND   = 3'd0;
    localparam logic [2:0] MODE_ACK    = 3'd1;
    localparam logic [2:0] MODE_CANCEL = 3'd2;
    localparam logic [2:0] MODE_TICK   = 3'd3;
    localparam logic [2:0] MODE_FORCE  = 3'd4;

    localparam logic [1:0] EV_SEND    = 2'd0;
    localparam logic [1:0] EV_CONFIRM = 2'd1;
    localparam logic [1:0] EV_FAIL    = 2'd2;
    localparam logic [1:0] EV_RETRY   = 2'd3;

    localparam logic [1:0] PRIO_ROUTINE = 2'd0;
    localparam logic [1:0] PRIO_INVALID = 2'd3;

    localparam logic [2:0] REG_BASE       = 3'd0;
    localparam logic [2:0] REG_JITTER     = 3'd1;
    localparam logic [2:0] REG_LIMIT_RT   = 3'd2;
    localparam logic [2:0] REG_LIMIT_UR   = 3'd3;
    localparam logic [2:0] REG_LIMIT_EM   = 3'd4;
    localparam logic [2:0] REG_CAP_RT     = 3'd5;
    localparam logic [2:0] REG_CAP_UR     = 3'd6;
    localparam logic [2:0] REG_CAP_EM     = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] msg_id;
        logic [1:0]  priority_req;
        logic        encode_ok;
        logic [15:0] jitter_draw;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [63:0] out_id;
        logic [1:0]  out_priority;
        logic [7:0]  attempt_number;
        logic [16:0] armed_backoff;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [63:0] id;
        logic [1:0]  prio;
        logic [7:0]  retries;
        logic [16:0] countdown;
    } entry_t;

    typedef struct packed {
        logic [15:0]       base;
        logic [6:0]        jit;
        logic [2:0][8:0]   limit;
        logic [2:0][15:0]  cap;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_ALLOC,
        ST_SEND,
        ST_DROP,
        ST_EXPIRE,
        ST_EXP_FAIL,
        ST_BACKOFF,
        ST_ARM,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/retransmit_timer_table_unit.sv
// ----------------------------------------------------------------------------
// retransmit_timer_table_unit
// Retransmission timer table with exponential backoff and jitter.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready; one request is worked at a time and
// in_ready is high only while the sequencer is idle. Results leave on
// out_valid/out_ready, 0 to 32 per request, the final one flagged by last.
// Registers are written through the APB port (pready tied high); the user
// must write them only while idle, as the block itself does not enforce it.
// Send, ack, cancel and force scan slots until the id is found, each slot a
// memory read then a compare, and then emit any result and finish. A tick
// scans every slot; a slot that fails on its limit adds an expire step, and
// a retried slot adds expire, backoff and arm steps. Each armed countdown
// passes through the backoff pipeline. The sequencer returns to idle between
// requests.
// Reset clears the slot valid bits and loads the register defaults; no
// clearing pass is needed. A stalled receiver fills the output register and
// the pending-result register, after which the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module retransmit_timer_table_unit #(
    parameter int TABLE_DEPTH = rtt_pkg::TABLE_DEPTH_DEF,
    parameter int SHIFT_CAP   = rtt_pkg::SHIFT_CAP_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire rtt_pkg::in_item_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output rtt_pkg::out_item_t               out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rtt_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(TABLE_DEPTH - 1);

    rtt_pkg::state_t   state_reg;
    rtt_pkg::state_t   state_next;
    rtt_pkg::cfg_t     cfg_reg;
    rtt_pkg::in_item_t item_reg;
    rtt_pkg::in_item_t in_fix;
    rtt_pkg::entry_t   work_reg;
    rtt_pkg::entry_t   rd_data;
    rtt_pkg::entry_t   mem_wdata;
    rtt_pkg::out_item_t emit_item;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [IDXW-1:0] idx_reg;
    logic [IDXW-1:0] slot_reg;
    logic [IDXW-1:0] free_idx_reg;
    logic            free_found_reg;
    logic [5:0]      n_reg;
    logic [16:0]     arm_reg;

    logic [2:0]  reg_idx;
    logic        cfg_we;
    logic        accept;
    logic        mem_we;
    logic [IDXW-1:0] mem_waddr;
    logic        emit;
    logic        emit_ok;
    logic        flush;
    logic        valid_set;
    logic        valid_clr;
    logic        idx_step;
    logic        bo_start;
    logic        bo_done;
    logic [16:0] bo_arm;
    logic [7:0]  bo_retries;
    logic        retry_bump;
    logic        alloc_load;

    logic        v_cur;
    logic        hit;
    logic        last_slot;
    logic        is_tick;
    logic        cd_dec;
    logic        tick_full;
    logic [1:0]  lsel;
    logic [8:0]  lr;
    logic        limit_fail;
    logic [7:0]  ret_inc;
    logic [1:0]  pr_in;

    // ---------------- configuration ----------------
    assign reg_idx = paddr[rtt_pkg::PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base     <= 16'd1000;
            cfg_reg.jit      <= 7'd20;
            cfg_reg.limit[0] <= 9'd3;
            cfg_reg.limit[1] <= 9'd5;
            cfg_reg.limit[2] <= 9'h1FF;
            cfg_reg.cap[0]   <= 16'd30000;
            cfg_reg.cap[1]   <= 16'd15000;
            cfg_reg.cap[2]   <= 16'd5000;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                rtt_pkg::REG_BASE:     cfg_reg.base     <= pwdata[15:0];
                rtt_pkg::REG_JITTER:   cfg_reg.jit      <= pwdata[6:0];
                rtt_pkg::REG_LIMIT_RT: cfg_reg.limit[0] <= pwdata[8:0];
                rtt_pkg::REG_LIMIT_UR: cfg_reg.limit[1] <= pwdata[8:0];
                rtt_pkg::REG_LIMIT_EM: cfg_reg.limit[2] <= pwdata[8:0];
                rtt_pkg::REG_CAP_RT:   cfg_reg.cap[0]   <= pwdata[15:0];
                rtt_pkg::REG_CAP_UR:   cfg_reg.cap[1]   <= pwdata[15:0];
                rtt_pkg::REG_CAP_EM:   cfg_reg.cap[2]   <= pwdata[15:0];
                default:               cfg_reg.base     <= cfg_reg.base;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rtt_pkg::REG_BASE:     prdata = 32'(cfg_reg.base);
            rtt_pkg::REG_JITTER:   prdata = 32'(cfg_reg.jit);
            rtt_pkg::REG_LIMIT_RT: prdata = 32'(cfg_reg.limit[0]);
            rtt_pkg::REG_LIMIT_UR: prdata = 32'(cfg_reg.limit[1]);
            rtt_pkg::REG_LIMIT_EM: prdata = 32'(cfg_reg.limit[2]);
            rtt_pkg::REG_CAP_RT:   prdata = 32'(cfg_reg.cap[0]);
            rtt_pkg::REG_CAP_UR:   prdata = 32'(cfg_reg.cap[1]);
            rtt_pkg::REG_CAP_EM:   prdata = 32'(cfg_reg.cap[2]);
            default:               prdata = '0;
        endcase
    end

    // ---------------- shared decode ----------------
    assign in_ready  = (state_reg == rtt_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign pr_in     = (in_data.priority_req == rtt_pkg::PRIO_INVALID) ?
                       rtt_pkg::PRIO_ROUTINE : in_data.priority_req;
    assign v_cur     = valid_reg[idx_reg];
    assign hit       = v_cur && (rd_data.id == item_reg.msg_id);
    assign last_slot = (idx_reg == IDX_LAST);
    assign is_tick   = (item_reg.mode == rtt_pkg::MODE_TICK);
    assign cd_dec    = rd_data.countdown > 17'd1;
    assign tick_full = (7'(n_reg) + 7'd2) > 7'(rtt_pkg::MAX_RES);
    assign lsel      = (work_reg.prio == rtt_pkg::PRIO_INVALID) ?
                       rtt_pkg::PRIO_ROUTINE : work_reg.prio;
    assign lr        = cfg_reg.limit[lsel];
    assign limit_fail = !lr[8] && (work_reg.retries >= lr[7:0]);
    assign ret_inc   = (work_reg.retries == 8'hFF) ? 8'hFF : work_reg.retries + 8'd1;
    assign bo_retries = (state_reg == rtt_pkg::ST_EXPIRE) ? ret_inc : work_reg.retries;

    always_comb
    begin
        in_fix              = in_data;
        in_fix.priority_req = pr_in;
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode inside {[rtt_pkg::MODE_SEND:rtt_pkg::MODE_FORCE]})
                    begin
                        state_next = rtt_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = rtt_pkg::ST_FINISH;
                    end
                end
            end
            rtt_pkg::ST_READ:
            begin
                state_next = rtt_pkg::ST_CHECK;
            end
            rtt_pkg::ST_CHECK:
            begin
                if (is_tick)
                begin
                    if (!v_cur || cd_dec || tick_full)
                    begin
                        state_next = last_slot ? rtt_pkg::ST_FINISH : rtt_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = rtt_pkg::ST_EXPIRE;
                    end
                end
                else if (hit)
                begin
                    case (item_reg.mode)
                        rtt_pkg::MODE_SEND:  state_next = rtt_pkg::ST_SEND;
                        rtt_pkg::MODE_FORCE: state_next = rtt_pkg::ST_EXPIRE;
                        default:             state_next = rtt_pkg::ST_DROP;
                    endcase
                end
                else if (last_slot)
                begin
                    state_next = (item_reg.mode == rtt_pkg::MODE_SEND) ?
                                 rtt_pkg::ST_ALLOC : rtt_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = rtt_pkg::ST_READ;
                end
            end
            rtt_pkg::ST_ALLOC:
            begin
                if (free_found_reg)
                begin
                    state_next = rtt_pkg::ST_SEND;
                end
                else if (emit_ok)
                begin
                    state_next = rtt_pkg::ST_FINISH;
                end
            end
            rtt_pkg::ST_SEND:
            begin
                if (item_reg.encode_ok)
                begin
                    state_next = rtt_pkg::ST_BACKOFF;
                end
                else if (emit_ok)
                begin
                    state_next = rtt_pkg::ST_FINISH;
                end
            end
            rtt_pkg::ST_DROP:
            begin
                if (emit_ok)
                begin
                    state_next = rtt_pkg::ST_FINISH;
                end
            end
            rtt_pkg::ST_EXPIRE:
            begin
                if (emit_ok)
                begin
                    if (limit_fail)
                    begin
                        state_next = (is_tick && !last_slot) ?
                                     rtt_pkg::ST_READ : rtt_pkg::ST_FINISH;
                    end
                    else if (item_reg.encode_ok)
                    begin
                        state_next = rtt_pkg::ST_BACKOFF;
                    end
                    else
                    begin
                        state_next = rtt_pkg::ST_EXP_FAIL;
                    end
                end
            end
            rtt_pkg::ST_BACKOFF:
            begin
                if (bo_done)
                begin
                    state_next = rtt_pkg::ST_ARM;
                end
            end
            rtt_pkg::ST_ARM, rtt_pkg::ST_EXP_FAIL:
            begin
                if (emit_ok)
                begin
                    state_next = (is_tick && !last_slot) ?
                                 rtt_pkg::ST_READ : rtt_pkg::ST_FINISH;
                end
            end
            rtt_pkg::ST_FINISH:
            begin
                if (emit_ok)
                begin
                    state_next = rtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtt_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- actions ----------------
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = rd_data;
        emit       = 1'b0;
        emit_item  = '0;
        flush      = 1'b0;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        idx_step   = 1'b0;
        bo_start   = 1'b0;
        retry_bump = 1'b0;
        alloc_load = 1'b0;
        emit_item.out_id       = work_reg.id;
        emit_item.out_priority = work_reg.prio;
        case (state_reg)
            rtt_pkg::ST_CHECK:
            begin
                if (is_tick)
                begin
                    if (v_cur && cd_dec)
                    begin
                        mem_we              = 1'b1;
                        mem_wdata.countdown = rd_data.countdown - 17'd1;
                    end
                    else if (v_cur && tick_full)
                    begin
                        mem_we              = 1'b1;
                        mem_wdata.countdown = 17'd1;
                    end
                    idx_step = (!v_cur || cd_dec || tick_full) && !last_slot;
                end
                else
                begin
                    idx_step = !hit && !last_slot;
                end
            end
            rtt_pkg::ST_ALLOC:
            begin
                alloc_load = free_found_reg;
                if (!free_found_reg)
                begin
                    emit                   = 1'b1;
                    emit_item.event_res    = rtt_pkg::EV_FAIL;
                    emit_item.out_id       = item_reg.msg_id;
                    emit_item.out_priority = item_reg.priority_req;
                end
            end
            rtt_pkg::ST_SEND:
            begin
                if (item_reg.encode_ok)
                begin
                    bo_start = 1'b1;
                end
                else
                begin
                    emit                   = 1'b1;
                    valid_clr              = emit_ok;
                    emit_item.event_res    = rtt_pkg::EV_FAIL;
                    emit_item.out_priority = item_reg.priority_req;
                end
            end
            rtt_pkg::ST_DROP:
            begin
                emit                = 1'b1;
                valid_clr           = emit_ok;
                emit_item.event_res = (item_reg.mode == rtt_pkg::MODE_ACK) ?
                                      rtt_pkg::EV_CONFIRM : rtt_pkg::EV_FAIL;
            end
            rtt_pkg::ST_EXPIRE:
            begin
                emit = 1'b1;
                if (limit_fail)
                begin
                    valid_clr           = emit_ok;
                    emit_item.event_res = rtt_pkg::EV_FAIL;
                    idx_step            = emit_ok && is_tick && !last_slot;
                end
                else
                begin
                    emit_item.event_res      = rtt_pkg::EV_RETRY;
                    emit_item.attempt_number = ret_inc;
                    retry_bump               = emit_ok;
                    bo_start                 = emit_ok && item_reg.encode_ok;
                end
            end
            rtt_pkg::ST_EXP_FAIL:
            begin
                emit                = 1'b1;
                valid_clr           = emit_ok;
                emit_item.event_res = rtt_pkg::EV_FAIL;
                idx_step            = emit_ok && is_tick && !last_slot;
            end
            rtt_pkg::ST_ARM:
            begin
                emit                    = 1'b1;
                mem_we                  = emit_ok;
                mem_waddr               = slot_reg;
                mem_wdata               = work_reg;
                mem_wdata.countdown     = arm_reg;
                valid_set               = emit_ok;
                emit_item.event_res     = rtt_pkg::EV_SEND;
                emit_item.armed_backoff = arm_reg;
                if (item_reg.mode == rtt_pkg::MODE_SEND)
                begin
                    emit_item.out_priority = item_reg.priority_req;
                end
                idx_step = emit_ok && is_tick && !last_slot;
            end
            rtt_pkg::ST_FINISH:
            begin
                flush = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // ---------------- control and datapath registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rtt_pkg::ST_IDLE;
            valid_reg      <= '0;
            free_found_reg <= 1'b0;
            n_reg          <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (valid_set)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            else if (valid_clr)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end
            if (accept)
            begin
                free_found_reg <= 1'b0;
                n_reg          <= '0;
                idx_reg        <= '0;
            end
            else
            begin
                if (state_reg == rtt_pkg::ST_CHECK && !is_tick && !v_cur && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (emit && emit_ok)
                begin
                    n_reg <= n_reg + 6'd1;
                end
                if (idx_step)
                begin
                    idx_reg <= idx_reg + IDXW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_fix;
        end
        if (state_reg == rtt_pkg::ST_CHECK)
        begin
            work_reg <= rd_data;
            slot_reg <= idx_reg;
            if (!is_tick && !v_cur && !free_found_reg)
            begin
                free_idx_reg <= idx_reg;
            end
        end
        else if (alloc_load)
        begin
            work_reg.id        <= item_reg.msg_id;
            work_reg.prio      <= item_reg.priority_req;
            work_reg.retries   <= '0;
            work_reg.countdown <= '0;
            slot_reg           <= free_idx_reg;
        end
        else if (retry_bump)
        begin
            work_reg.retries <= ret_inc;
        end
        if (bo_done)
        begin
            arm_reg <= bo_arm;
        end
    end

    // ---------------- submodules ----------------
    rtt_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IDXW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (state_reg == rtt_pkg::ST_READ),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    rtt_backoff #(
        .SHIFT_CAP (SHIFT_CAP)
    ) u_backoff (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (bo_start),
        .prio    (work_reg.prio),
        .retries (bo_retries),
        .draw    (item_reg.jitter_draw),
        .cfg     (cfg_reg),
        .done    (bo_done),
        .arm     (bo_arm)
    );

    rtt_result_buf u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .emit_item (emit_item),
        .flush     (flush),
        .emit_ok   (emit_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/rtt_table_mem.sv
// ----------------------------------------------------------------------------
// rtt_table_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_table_mem #(
    parameter int DEPTH = rtt_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire rtt_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output rtt_pkg::entry_t      rdata
);

    rtt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rtt_backoff.sv
// ----------------------------------------------------------------------------
// rtt_backoff
// Six-stage backoff pipeline: shift and cap, jitter span, jitter pick, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_backoff #(
    parameter int SHIFT_CAP = rtt_pkg::SHIFT_CAP_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    prio,
    input  wire logic [7:0]    retries,
    input  wire logic [15:0]   draw,
    input  wire rtt_pkg::cfg_t cfg,
    output logic               done,
    output logic [16:0]        arm
);

    localparam int BW = 16 + SHIFT_CAP;

    logic [5:0]  vld_reg;
    logic [15:0] b_reg [5];
    logic [15:0] draw_reg [4];
    logic [22:0] prod_reg [2];
    logic [16:0] q0_reg;
    logic [16:0] r_reg [2];
    logic [17:0] pick_reg;
    logic [16:0] arm_reg;

    logic [7:0]    sh;
    logic [BW-1:0] shifted;
    logic [1:0]    psel;
    logic [15:0]   cap;
    logic [46:0]   recip_prod;
    logic [23:0]   q_x100;
    logic [23:0]   rem;
    logic [33:0]   pick_full;
    logic signed [19:0] v;

    always_comb
    begin
        sh         = (retries < 8'(SHIFT_CAP)) ? retries : 8'(SHIFT_CAP);
        shifted    = BW'(cfg.base) << sh;
        psel       = (prio == rtt_pkg::PRIO_INVALID) ? rtt_pkg::PRIO_ROUTINE : prio;
        cap        = cfg.cap[psel];
        recip_prod = 47'(prod_reg[0]) * 47'(rtt_pkg::RECIP_M);
        q_x100     = {1'b0, q0_reg, 6'b0} + {2'b0, q0_reg, 5'b0} + {5'b0, q0_reg, 2'b0};
        rem        = {1'b0, prod_reg[1]} - q_x100;
        pick_full  = 34'(draw_reg[3]) * 34'({r_reg[0], 1'b1});
        v          = $signed({4'b0, b_reg[4]}) + $signed({2'b0, pick_reg})
                     - $signed({3'b0, r_reg[1]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg[0]    <= (shifted > BW'(cap)) ? cap : shifted[15:0];
        draw_reg[0] <= draw;
        b_reg[1]    <= b_reg[0];
        draw_reg[1] <= draw_reg[0];
        prod_reg[0] <= 23'(b_reg[0]) * 23'(cfg.jit);
        b_reg[2]    <= b_reg[1];
        draw_reg[2] <= draw_reg[1];
        prod_reg[1] <= prod_reg[0];
        q0_reg      <= recip_prod[46:rtt_pkg::RECIP_SHIFT];
        b_reg[3]    <= b_reg[2];
        draw_reg[3] <= draw_reg[2];
        r_reg[0]    <= (rem >= 24'd100) ? q0_reg + 17'd1 : q0_reg;
        b_reg[4]    <= b_reg[3];
        r_reg[1]    <= r_reg[0];
        pick_reg    <= pick_full[33:16];
        if (v < 20'sd100)
        begin
            arm_reg <= 17'(rtt_pkg::MIN_BACKOFF);
        end
        else if (v > 20'sd131071)
        begin
            arm_reg <= 17'(rtt_pkg::ARM_MAX);
        end
        else
        begin
            arm_reg <= v[16:0];
        end
    end

    assign done = vld_reg[5];
    assign arm  = arm_reg;

endmodule

`default_nettype wire

FILE: rtl/rtt_result_buf.sv
// ----------------------------------------------------------------------------
// rtt_result_buf
// Holds one pending result so the final one can be marked, plus the output
// register toward the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_result_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               emit,
    input  wire rtt_pkg::out_item_t emit_item,
    input  wire logic               flush,
    output logic                    emit_ok,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rtt_pkg::out_item_t      out_data
);

    logic               pend_valid_reg;
    rtt_pkg::out_item_t pend_reg;
    logic               out_valid_reg;
    rtt_pkg::out_item_t out_reg;
    rtt_pkg::out_item_t push_item;
    logic               out_free;
    logic               push;

    assign out_free = !out_valid_reg || out_ready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign push     = pend_valid_reg && emit_ok && (emit || flush);

    always_comb
    begin
        push_item      = pend_reg;
        push_item.last = flush && !emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit && emit_ok)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush && emit_ok)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && emit_ok)
        begin
            pend_reg <= emit_item;
        end
        if (push)
        begin
            out_reg <= push_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
